/* hw/rtl/mips_subset_execute_unit_defines.svh */
// Assertion macros used by the execute unit back end RTL.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MSX_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MSX_ASSERT(lbl, prop, msg)
`define MSX_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/msx_pkg.sv */
// Types, encodings and sizes shared by the execute unit modules.
package msx_pkg;

    localparam int MEM_WORDS    = 1024;
    localparam int MEM_AW       = $clog2(MEM_WORDS);
    localparam int XLEN         = 32;
    localparam int REG_AW       = 5;
    localparam int NUM_REGS     = 32;
    localparam int ADDR_OUT_W   = 10;
    localparam int QUEUE_DEPTH  = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_FIELDS_W = 1 + REG_AW + XLEN + 1 + ADDR_OUT_W + XLEN;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 2;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        K_ADD, K_SUB, K_AND, K_OR, K_SLT, K_ADDI, K_LW, K_SW, K_INVALID
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [REG_AW-1:0]  rs;
        logic [REG_AW-1:0]  rt;
        logic [REG_AW-1:0]  dest;
        logic [XLEN-1:0]    simm;
    } t_uop;

    typedef struct packed {
        t_status                  status;
        logic                     reg_written;
        logic [REG_AW-1:0]        reg_index;
        logic signed [XLEN-1:0]   reg_value;
        logic                     mem_written;
        logic [ADDR_OUT_W-1:0]    mem_addr;
        logic signed [XLEN-1:0]   mem_value;
    } t_result;

endpackage

/* hw/rtl/msx_front.sv */
// Front end: input handshake and instruction decode into a micro-op.
module msx_front (
    input  logic                               i_tvalid,
    input  logic [msx_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic                               i_queue_full,
    input  logic                               i_clearing,
    output logic                               o_tready,
    output logic                               o_push,
    output msx_pkg::t_uop                      o_uop
);
    import msx_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;

    assign op       = i_tdata[31:26];
    assign fn       = i_tdata[5:0];
    assign o_tready = !i_queue_full && !i_clearing;
    assign o_push   = i_tvalid && o_tready;

    always_comb begin
        o_uop.rs   = i_tdata[25:21];
        o_uop.rt   = i_tdata[20:16];
        o_uop.dest = i_tdata[20:16];
        o_uop.simm = {{(XLEN - 16){i_tdata[15]}}, i_tdata[15:0]};
        o_uop.kind = K_INVALID;
        case (op)
            OP_RTYPE: begin
                o_uop.dest = i_tdata[15:11];
                case (fn)
                    FN_ADD:  o_uop.kind = K_ADD;
                    FN_SUB:  o_uop.kind = K_SUB;
                    FN_AND:  o_uop.kind = K_AND;
                    FN_OR:   o_uop.kind = K_OR;
                    FN_SLT:  o_uop.kind = K_SLT;
                    default: o_uop.kind = K_INVALID;
                endcase
            end
            OP_ADDI: o_uop.kind = K_ADDI;
            OP_LW:   o_uop.kind = K_LW;
            OP_SW:   o_uop.kind = K_SW;
            default: o_uop.kind = K_INVALID;
        endcase
    end

endmodule

/* hw/rtl/msx_queue.sv */
// Small FIFO of decoded micro-ops between the front and back ends.
module msx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  msx_pkg::t_uop i_uop,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output msx_pkg::t_uop o_uop
);
    import msx_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_uop             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_uop   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_uop;
        end
    end

endmodule

/* hw/rtl/msx_back.sv */
// Back end: register file, data memory, execution and result register.
`include "mips_subset_execute_unit_defines.svh"

module msx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_uop_valid,
    input  msx_pkg::t_uop   i_uop,
    output logic            o_pop,
    output logic            o_clearing,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output msx_pkg::t_result o_res
);
    import msx_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_READ, S_EXEC, S_LOAD} t_state;

    t_state              r_state;
    t_state              n_state;
    logic [MEM_AW-1:0]   r_clr_addr;
    t_uop                r_uop;
    logic [XLEN-1:0]     r_a;
    logic [XLEN-1:0]     r_b;
    logic [XLEN-1:0]     r_mrd;
    logic                r_out_valid;
    t_result             r_out;
    logic [XLEN-1:0]     r_rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;
    logic [XLEN-1:0]     r_dmem [MEM_WORDS];

    logic [XLEN-1:0]     addr;
    logic [XLEN-1:0]     alu;
    logic                in_range;
    logic                slot_free;
    logic                rf_we;
    logic [XLEN-1:0]     rf_wd;
    logic                mem_we;
    logic                mem_re;
    logic [MEM_AW-1:0]   mem_a;
    logic [XLEN-1:0]     mem_wd;
    logic                res_load;
    t_result             res;

    assign addr        = r_a + r_uop.simm;
    assign in_range    = (addr < XLEN'(MEM_WORDS));
    assign slot_free   = !r_out_valid || i_res_ready;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        case (r_uop.kind)
            K_ADD:   alu = r_a + r_b;
            K_SUB:   alu = r_a - r_b;
            K_AND:   alu = r_a & r_b;
            K_OR:    alu = r_a | r_b;
            K_SLT:   alu = {{(XLEN - 1){1'b0}}, ($signed(r_a) < $signed(r_b))};
            default: alu = addr;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        rf_we    = 1'b0;
        rf_wd    = alu;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_a    = addr[MEM_AW-1:0];
        mem_wd   = r_b;
        res_load = 1'b0;
        res      = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_a  = r_clr_addr;
                mem_wd = '0;
                if (r_clr_addr == MEM_AW'(MEM_WORDS - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_uop_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_uop.kind == K_LW && in_range) begin
                    mem_re  = 1'b1;
                    n_state = S_LOAD;
                end else if (slot_free) begin
                    res_load = 1'b1;
                    n_state  = S_READ;
                    case (r_uop.kind)
                        K_ADD, K_SUB, K_AND, K_OR, K_SLT, K_ADDI: begin
                            rf_we = (r_uop.dest != '0);
                        end
                        K_LW, K_SW: begin
                            res.mem_addr = addr[ADDR_OUT_W-1:0];
                            if (!in_range) begin
                                res.status = ST_RANGE;
                            end else begin
                                mem_we          = 1'b1;
                                res.mem_written = 1'b1;
                                res.mem_value   = r_b;
                            end
                        end
                        default: res.status = ST_INVALID;
                    endcase
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    res_load     = 1'b1;
                    n_state      = S_READ;
                    rf_wd        = r_mrd;
                    rf_we        = (r_uop.dest != '0);
                    res.mem_addr = addr[ADDR_OUT_W-1:0];
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (rf_we) begin
            res.reg_written = 1'b1;
            res.reg_index   = r_uop.dest;
            res.reg_value   = rf_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_rf_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (rf_we) begin
                r_rf_vld[r_uop.dest] <= 1'b1;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_uop <= i_uop;
            r_a   <= r_rf_vld[i_uop.rs] ? r_rf[i_uop.rs] : '0;
            r_b   <= r_rf_vld[i_uop.rt] ? r_rf[i_uop.rt] : '0;
        end
        if (rf_we) begin
            r_rf[r_uop.dest] <= rf_wd;
        end
        if (res_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_dmem[mem_a] <= mem_wd;
        end
        if (mem_re) begin
            r_mrd <= r_dmem[mem_a];
        end
    end

    `MSX_ASSERT(a_reg_zero_never_written, !r_rf_vld[0], "Register zero was marked as written.")
    `MSX_ASSERT_IMPL(a_no_result_in_clear, r_state == S_CLEAR, !r_out_valid, "Result during memory clear.")
    `MSX_ASSERT_IMPL(a_store_only_from_sw, mem_we && r_state != S_CLEAR, r_uop.kind == K_SW, "Memory write without a store.")
    `MSX_ASSERT_IMPL(a_load_after_exec, r_state == S_LOAD, $past(r_state) == S_EXEC || $past(r_state) == S_LOAD, "Load state entered out of order.")

endmodule

/* hw/rtl/mips_subset_execute_unit.sv */
// Top level of the MIPS subset execute unit.
// Each input item is one instruction word and yields exactly one result item. After reset the
// unit clears every data memory word to zero and accepts no item during that time. Afterwards
// each item passes a register file read state, then an execute and write back state; an in-range
// load issues the data memory read in the execute state and writes back in a separate load state.
// The back end takes a new item from the queue only after the last one is written back, and
// waits while the result register holds a result not yet taken. A two-entry queue after the
// decoder and a result register let input and output stall independently.
module mips_subset_execute_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // instruction_word[31:0]
    input  logic [msx_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // reg_written[0], reg_index[5:1], reg_value[37:6], mem_written[38],
    // mem_addr[48:39], mem_value[80:49], zero padding above
    output logic [msx_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status[1:0]
    output logic [msx_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser
);
    import msx_pkg::*;

    t_uop    dec_uop;
    t_uop    q_uop;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    logic    clearing;
    t_result res;

    msx_front u_front (
        .i_tvalid     (i_s_axis_tvalid),
        .i_tdata      (i_s_axis_tdata),
        .i_queue_full (q_full),
        .i_clearing   (clearing),
        .o_tready     (o_s_axis_tready),
        .o_push       (push),
        .o_uop        (dec_uop)
    );

    msx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (dec_uop),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_uop   (q_uop)
    );

    msx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (q_valid),
        .i_uop       (q_uop),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.mem_value, res.mem_addr, res.mem_written,
                             res.reg_value, res.reg_index, res.reg_written};
    assign o_m_axis_tuser = res.status;

endmodule
